>>> rtl/core/pih_pkg.sv
// Package for the packet interval histogram: sizes, codes, payload types.
// Used by pih_front, pih_back, pih_res_q and packet_interval_histogram.
// No dependencies.
`default_nettype none

package pih_pkg;

	// Stream space and counter width
	localparam int TRAJECTORIES          = 4;
	localparam int FRAMES_PER_TRAJECTORY = 16;
	localparam int COUNT_BITS            = 32;

	localparam int NUM_BUCKETS = 9;
	localparam int NUM_LIMITS  = 8;
	localparam int LAST_BUCKET = NUM_BUCKETS - 1;
	localparam int STREAMS     = TRAJECTORIES * FRAMES_PER_TRAJECTORY;
	localparam int COUNTERS    = STREAMS * NUM_BUCKETS;
	localparam int STREAM_W    = (STREAMS > 1) ? $clog2(STREAMS) : 1;
	localparam int CNT_AW      = $clog2(COUNTERS);

	// Fixed field widths
	localparam int OP_W        = 2;
	localparam int TRAJ_W      = 2;
	localparam int FRAME_W     = 4;
	localparam int TIME_W      = 63;
	localparam int BUCKET_W    = 4;
	localparam int HITS_W      = 32;
	localparam int LIMIT_W     = 32;
	localparam int LIMIT_IDX_W = 3;

	localparam logic [63:0] HITS_MAX = 64'h0000_0000_FFFF_FFFF;

	// Queue depths (powers of two)
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_AW    = 1;
	localparam int RESQ_DEPTH = 2;
	localparam int RESQ_AW    = 1;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET [NUM_LIMITS] = '{
		32'd10000, 32'd30000, 32'd50000, 32'd70000,
		32'd100000, 32'd300000, 32'd1000000, 32'd5000000
	};

	typedef enum logic [OP_W-1:0] {
		OP_SAMPLE = 2'd0,
		OP_READ   = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [TRAJ_W-1:0]  trajectory;
		logic [FRAME_W-1:0] frame;
		logic [TIME_W-1:0]  arrival_time;
	} pih_in_t;

	typedef struct packed {
		logic [BUCKET_W-1:0] bucket;
		logic [HITS_W-1:0]   hits;
		logic                stream_seen;
		logic                last;
	} pih_res_t;

	// Classified command handed from front to back
	typedef struct packed {
		op_t                 op;
		logic                stream_ok;
		logic [STREAM_W-1:0] stream;
		logic [TIME_W-1:0]   arrival_time;
	} pih_cmd_t;

	typedef struct packed {
		logic     valid;
		pih_cmd_t cmd;
	} pih_head_t;

endpackage

`default_nettype wire

>>> rtl/core/pih_front.sv
// Front end: accepts input beats, classifies them and queues commands.
// Depends on pih_pkg.
`default_nettype none

module pih_front import pih_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  pih_in_t   item,
	output pih_head_t head,
	input  logic      head_pop
);

	localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

	pih_cmd_t            cmd;
	logic                keep;
	logic                stream_ok;
	logic                enq;
	logic                deq;
	pih_cmd_t            cmdq_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0]  wr_q;
	logic [CMDQ_AW-1:0]  rd_q;
	logic [CNT_W-1:0]    cnt_q;

	// Classify: build the stream index, drop unused codes and stray samples
	always_comb begin
		stream_ok = (32'(item.trajectory) < TRAJECTORIES) &&
			(32'(item.frame) < FRAMES_PER_TRAJECTORY);
		cmd.op = op_t'(item.op);
		cmd.stream_ok = stream_ok;
		cmd.stream = STREAM_W'(32'(item.trajectory) * FRAMES_PER_TRAJECTORY +
			32'(item.frame));
		cmd.arrival_time = item.arrival_time;
		keep = ((item.op == OP_SAMPLE) && stream_ok) || (item.op == OP_READ) ||
			(item.op == OP_CLEAR);
	end

	assign full = (cnt_q == CNT_W'(CMDQ_DEPTH));
	assign enq  = push && !full && keep;
	assign deq  = head_pop && (cnt_q != '0);

	assign head.valid = (cnt_q != '0);
	assign head.cmd   = cmdq_q[rd_q];

	// Hold queued commands
	always_ff @(posedge clk) begin
		if (enq) begin
			cmdq_q[wr_q] <= cmd;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (enq) begin
				wr_q <= wr_q + 1'b1;
			end
			if (deq) begin
				rd_q <= rd_q + 1'b1;
			end
			if (enq && !deq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (deq && !enq) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/pih_res_q.sv
// Result queue: buffers result beats between the back end and the output.
// Depends on pih_pkg.
`default_nettype none

module pih_res_q import pih_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     res_push,
	input  pih_res_t res,
	output logic     res_full,
	output logic     empty,
	input  logic     pop,
	output pih_res_t result
);

	localparam int CNT_W = $clog2(RESQ_DEPTH + 1);

	pih_res_t           resq_q [RESQ_DEPTH];
	logic [RESQ_AW-1:0] wr_q;
	logic [RESQ_AW-1:0] rd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               enq;
	logic               deq;

	assign res_full = (cnt_q == CNT_W'(RESQ_DEPTH));
	assign empty    = (cnt_q == '0);
	assign enq      = res_push && !res_full;
	assign deq      = pop && !empty;
	assign result   = resq_q[rd_q];

	// Hold waiting beats
	always_ff @(posedge clk) begin
		if (enq) begin
			resq_q[wr_q] <= res;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (enq) begin
				wr_q <= wr_q + 1'b1;
			end
			if (deq) begin
				rd_q <= rd_q + 1'b1;
			end
			if (enq && !deq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (deq && !enq) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/pih_back.sv
// Back end: seen flags, last-time and counter memories, bucket limits and
// the sequencer that executes sample, read and clear commands.
// Depends on pih_pkg.
`default_nettype none

module pih_back import pih_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pih_head_t              head,
	output logic                   head_pop,
	input  logic                   wr_en,
	input  logic [LIMIT_IDX_W-1:0] wr_index,
	input  logic [LIMIT_W-1:0]     wr_data,
	output logic                   res_push,
	output pih_res_t               res,
	input  logic                   res_full
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_ZERO  = 7'b0000010,
		ST_TIME  = 7'b0000100,
		ST_PICK  = 7'b0001000,
		ST_COUNT = 7'b0010000,
		ST_RADDR = 7'b0100000,
		ST_RDATA = 7'b1000000
	} state_t;

	state_t                 state_q;
	state_t                 state_d;
	logic [LIMIT_W-1:0]     limit_q [NUM_LIMITS];
	logic [STREAMS-1:0]     seen_q;
	logic [BUCKET_W-1:0]    idx_q;
	logic                   rd_seen_q;
	pih_cmd_t               cur_q;
	logic [TIME_W-1:0]      delta_q;
	logic                   neg_q;
	logic [CNT_AW-1:0]      cnt_addr_q;

	// Memories
	logic [TIME_W-1:0]      prev_mem [STREAMS];
	logic [COUNT_BITS-1:0]  cnt_mem [COUNTERS];
	logic [TIME_W-1:0]      prev_rd_q;
	logic [COUNT_BITS-1:0]  cnt_rd_q;

	logic                   prev_we;
	logic                   prev_re;
	logic [STREAM_W-1:0]    prev_wa;
	logic [TIME_W-1:0]      prev_wd;
	logic                   cnt_we;
	logic                   cnt_re;
	logic [CNT_AW-1:0]      cnt_wa;
	logic [CNT_AW-1:0]      cnt_ra;
	logic [COUNT_BITS-1:0]  cnt_wd;
	logic [CNT_AW-1:0]      base;
	logic [BUCKET_W-1:0]    pick_b;
	logic [COUNT_BITS-1:0]  cnt_inc;
	logic [HITS_W-1:0]      hits_sat;
	logic                   head_seen;

	// Counter row of the current stream
	assign base = CNT_AW'(CNT_AW'(cur_q.stream) * CNT_AW'(NUM_BUCKETS));
	assign head_seen = head.cmd.stream_ok && seen_q[head.cmd.stream];

	// Pick first bucket with limit above registered delta; 0 if negative
	always_comb begin
		pick_b = BUCKET_W'(LAST_BUCKET);
		for (int i = NUM_LIMITS - 1; i >= 0; i--) begin
			if (delta_q < TIME_W'(limit_q[i])) begin
				pick_b = BUCKET_W'(i);
			end
		end
		if (neg_q) begin
			pick_b = '0;
		end
	end

	// Saturate the increment and the reported count
	assign cnt_inc  = (cnt_rd_q == '1) ? cnt_rd_q : cnt_rd_q + COUNT_BITS'(1);
	assign hits_sat = (64'(cnt_rd_q) > HITS_MAX) ? '1 : HITS_W'(cnt_rd_q);

	// Sequencer
	always_comb begin
		state_d  = state_q;
		head_pop = 1'b0;
		prev_we  = 1'b0;
		prev_re  = 1'b0;
		cnt_we   = 1'b0;
		cnt_re   = 1'b0;
		cnt_wa   = base + CNT_AW'(idx_q);
		cnt_ra   = base + CNT_AW'(idx_q);
		cnt_wd   = '0;
		res_push = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (head.valid) begin
					head_pop = 1'b1;
					unique case (head.cmd.op)
						OP_SAMPLE: begin
							if (seen_q[head.cmd.stream]) begin
								prev_re = 1'b1;
								state_d = ST_TIME;
							end else begin
								prev_we = 1'b1;
								state_d = ST_ZERO;
							end
						end
						OP_READ: begin
							state_d = head_seen ? ST_RADDR : ST_RDATA;
						end
						OP_CLEAR: begin
							state_d = ST_IDLE;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_ZERO: begin
				cnt_we = 1'b1;
				if (idx_q == BUCKET_W'(LAST_BUCKET)) begin
					state_d = ST_IDLE;
				end
			end
			ST_TIME: begin
				prev_we = 1'b1;
				state_d = ST_PICK;
			end
			ST_PICK: begin
				cnt_re  = 1'b1;
				cnt_ra  = base + CNT_AW'(pick_b);
				state_d = ST_COUNT;
			end
			ST_COUNT: begin
				cnt_we  = 1'b1;
				cnt_wa  = cnt_addr_q;
				cnt_wd  = cnt_inc;
				state_d = ST_IDLE;
			end
			ST_RADDR: begin
				cnt_re  = 1'b1;
				state_d = ST_RDATA;
			end
			ST_RDATA: begin
				if (!res_full) begin
					res_push = 1'b1;
					if (idx_q == BUCKET_W'(LAST_BUCKET)) begin
						state_d = ST_IDLE;
					end else begin
						state_d = rd_seen_q ? ST_RADDR : ST_RDATA;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Last-time write: first sample writes from the queue head, later ones
	// from the held command
	assign prev_wa = (state_q == ST_IDLE) ? head.cmd.stream : cur_q.stream;
	assign prev_wd = (state_q == ST_IDLE) ? head.cmd.arrival_time : cur_q.arrival_time;

	// Result beat
	assign res.bucket      = idx_q;
	assign res.hits        = rd_seen_q ? hits_sat : '0;
	assign res.stream_seen = rd_seen_q;
	assign res.last        = (idx_q == BUCKET_W'(LAST_BUCKET));

	// Last-time memory
	always_ff @(posedge clk) begin
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		if (prev_re) begin
			prev_rd_q <= prev_mem[head.cmd.stream];
		end
	end

	// Counter memory
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		if (cnt_re) begin
			cnt_rd_q <= cnt_mem[cnt_ra];
		end
	end

	// Hold the command and the delta
	always_ff @(posedge clk) begin
		if (head_pop) begin
			cur_q <= head.cmd;
		end
		if (state_q == ST_TIME) begin
			delta_q <= cur_q.arrival_time - prev_rd_q;
			neg_q   <= (cur_q.arrival_time < prev_rd_q);
		end
		if (state_q == ST_PICK) begin
			cnt_addr_q <= cnt_ra;
		end
	end

	// Control state, seen flags and limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			seen_q    <= '0;
			idx_q     <= '0;
			rd_seen_q <= 1'b0;
			for (int i = 0; i < NUM_LIMITS; i++) begin
				limit_q[i] <= LIMIT_RESET[i];
			end
		end else begin
			state_q <= state_d;
			if (wr_en && (32'(wr_index) < NUM_LIMITS)) begin
				limit_q[wr_index] <= wr_data;
			end
			if (head_pop) begin
				idx_q     <= '0;
				rd_seen_q <= head_seen;
				if (head.cmd.op == OP_CLEAR) begin
					seen_q <= '0;
				end else if (head.cmd.op == OP_SAMPLE) begin
					seen_q[head.cmd.stream] <= 1'b1;
				end
			end else if ((state_q == ST_ZERO) || res_push) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Checks
	a_time_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TIME) |-> $past(prev_re))
		else $error("delta taken without a last-time read");

	a_count_after_pick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COUNT) |-> $past(state_q == ST_PICK))
		else $error("counter update without a bucket pick");

	a_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_we |-> !cnt_re)
		else $error("counter memory read and written together");

	a_last_ends_read: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.last) |=> (state_q == ST_IDLE))
		else $error("read continued past the last bucket");

	a_bucket_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (idx_q <= BUCKET_W'(LAST_BUCKET)))
		else $error("result beat with bucket out of range");

endmodule

`default_nettype wire

>>> rtl/core/packet_interval_histogram.sv
// Top level of the packet interval histogram: front end, back end and
// result queue. Depends on pih_pkg, pih_front, pih_back and pih_res_q.
//
// Channel   Handshake               Payload
// input     push / full             item   (pih_in_t)
// results   empty / pop             result (pih_res_t)
// config    wr_en, wr_index         wr_data (bucket limit, 32 bits)
//
// The front end takes a beat in any cycle that full is low and queues up to
// two commands. The back end works one command at a time: clear in the
// idle state alone, sample of a known stream in steps (last-time read,
// delta, bucket pick, counter read-modify-write), first sample of a
// stream by zeroing its nine counters, one per cycle through the single
// counter write port. A read of a known stream fetches each beat from the
// registered counter memory; any read also waits out output stalls. Reset
// clears the seen flags and queues at once, with no sweep.
`default_nettype none

module packet_interval_histogram import pih_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  pih_in_t                item,
	output logic                   empty,
	input  logic                   pop,
	output pih_res_t               result,
	input  logic                   wr_en,
	input  logic [LIMIT_IDX_W-1:0] wr_index,
	input  logic [LIMIT_W-1:0]     wr_data
);

	pih_head_t head;
	logic      head_pop;
	logic      res_push;
	pih_res_t  res;
	logic      res_full;

	pih_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.head     (head),
		.head_pop (head_pop)
	);

	pih_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.head_pop (head_pop),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.res_push (res_push),
		.res      (res),
		.res_full (res_full)
	);

	pih_res_q u_res_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res      (res),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

`default_nettype wire
